/* hdl/ppp_pkg.sv */
package ppp_pkg;

	localparam int SCREEN_BITS = 14;
	localparam int CFG_DATA_BITS = 32;

	typedef enum logic [1:0] {
		CFG_SCALE,
		CFG_TAN,
		CFG_WIDTH,
		CFG_HEIGHT
	} cfg_idx_t;

	localparam logic [CFG_DATA_BITS-1:0] SCALE_RESET = 32'd32768;
	localparam logic [CFG_DATA_BITS-1:0] TAN_RESET = 32'd65536;
	localparam logic [SCREEN_BITS-1:0] WIDTH_RESET = 14'd640;
	localparam logic [SCREEN_BITS-1:0] HEIGHT_RESET = 14'd480;

endpackage

/* hdl/ppp_div.sv */
module ppp_div #(
	parameter int DW = 64,
	parameter int VW = 31
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          out_valid,
	output logic [DW-1:0] quotient
);

	// One quotient bit per stage, restoring division, most significant bit first.
	logic          vld_s [DW+1];
	logic [DW-1:0] dvd_s [DW+1];
	logic [DW-1:0] quo_s [DW+1];
	logic [VW-1:0] rem_s [DW+1];
	logic [VW-1:0] dsr_s [DW+1];

	assign vld_s[0] = in_valid;
	assign dvd_s[0] = dividend;
	assign quo_s[0] = '0;
	assign rem_s[0] = '0;
	assign dsr_s[0] = divisor;

	for (genvar k = 0; k < DW; k++) begin : g_stage
		logic [VW:0] trial;
		logic [VW:0] diff;
		logic        ge;

		assign trial = {rem_s[k], dvd_s[k][DW-1]};
		assign diff = trial - {1'b0, dsr_s[k]};
		assign ge = trial >= {1'b0, dsr_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			dvd_s[k+1] <= {dvd_s[k][DW-2:0], 1'b0};
			quo_s[k+1] <= {quo_s[k][DW-2:0], ge};
			rem_s[k+1] <= ge ? diff[VW-1:0] : trial[VW-1:0];
			dsr_s[k+1] <= dsr_s[k];
		end
	end

	assign out_valid = vld_s[DW];
	assign quotient = quo_s[DW];

endmodule

/* hdl/perspective_point_projection.sv */
// Perspective projection of one 3D point (depth, across, up) to screen pixels.
// A point is taken as a transfer at a rising edge with start high and busy low.
// busy stays low: a new point may be started in every cycle.
// Each point gives one result on screen_x, screen_y and in_view, marked by
// done for exactly one cycle; the receiver cannot hold results off.
// The pipeline has two input stages, one stage per quotient bit in each of
// two pipelined dividers whose dividend is COORD_WIDTH + 32 bits wide, and
// four output stages.
// Throughput is one point per cycle.
// The four registers are written through the cfg channel; cfg_ready is always
// high, and a write should only be made while no points are in flight.
// Reset clears the pipeline valid bits and loads the register defaults:
// scale 0.5, tangent 1.0, screen 640 by 480.
module perspective_point_projection #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [COORD_WIDTH-1:0]     depth,
	input  logic signed [COORD_WIDTH-1:0]     across,
	input  logic signed [COORD_WIDTH-1:0]     up,
	output logic                              done,
	output logic signed [15:0]                screen_x,
	output logic signed [15:0]                screen_y,
	output logic                              in_view,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  ppp_pkg::cfg_idx_t                 cfg_index,
	input  logic [ppp_pkg::CFG_DATA_BITS-1:0] cfg_data
);

	import ppp_pkg::*;

	localparam int C = COORD_WIDTH;
	localparam int PW = C + 32;
	localparam int MW = FRAC_BITS + 17;
	localparam int QW = MW + 1;
	localparam int PXW = QW + SCREEN_BITS + 1;
	localparam int XW = PXW + 1;
	localparam int SBW = 2 * C + 4;
	localparam int LAT = PW + 6;
	localparam logic [PW-1:0] LIM = PW'(1) << (FRAC_BITS + 16);

	logic [CFG_DATA_BITS-1:0] scale_q;
	logic [CFG_DATA_BITS-1:0] tan_q;
	logic [SCREEN_BITS-1:0]   width_q;
	logic [SCREEN_BITS-1:0]   height_q;

	assign cfg_ready = 1'b1;
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
			tan_q <= TAN_RESET;
			width_q <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SCALE: scale_q <= cfg_data;
				CFG_TAN: tan_q <= cfg_data;
				CFG_WIDTH: width_q <= cfg_data[SCREEN_BITS-1:0];
				CFG_HEIGHT: height_q <= cfg_data[SCREEN_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Stage 1: input capture.
	logic                v_s1;
	logic signed [C-1:0] depth_s1;
	logic signed [C-1:0] across_s1;
	logic signed [C-1:0] up_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		depth_s1 <= depth;
		across_s1 <= across;
		up_s1 <= up;
	end

	// Stage 2: magnitudes and products.
	logic [C-1:0] ma;
	logic [C-1:0] mu;

	assign ma = across_s1[C-1] ? (~across_s1 + C'(1)) : across_s1;
	assign mu = up_s1[C-1] ? (~up_s1 + C'(1)) : up_s1;

	logic          v_s2;
	logic [PW-1:0] pdx_s2;
	logic [PW-1:0] pdy_s2;
	logic [PW-1:0] vprod_s2;
	logic [PW-1:0] acr_s2;
	logic          dpos_s2;
	logic          sx_s2;
	logic          sy_s2;
	logic [C-1:0]  ma_s2;
	logic [C-1:0]  mu_s2;
	logic [C-2:0]  dsr_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		pdx_s2 <= PW'(ma) * PW'(scale_q);
		pdy_s2 <= PW'(mu) * PW'(scale_q);
		vprod_s2 <= PW'(tan_q) * PW'(unsigned'(depth_s1));
		acr_s2 <= PW'(unsigned'(across_s1)) << FRAC_BITS;
		dpos_s2 <= !depth_s1[C-1] && (depth_s1 != '0);
		sx_s2 <= across_s1[C-1];
		sy_s2 <= up_s1[C-1];
		ma_s2 <= ma;
		mu_s2 <= mu;
		dsr_s2 <= (!depth_s1[C-1] && (depth_s1 != '0)) ? depth_s1[C-2:0] : (C-1)'(1);
	end

	logic view_s2;
	assign view_s2 = dpos_s2 && (sx_s2 || (acr_s2 < vprod_s2));

	// Dividers, with the side information delayed alongside.
	logic          div_vx;
	logic          div_vy;
	logic [PW-1:0] quo_x;
	logic [PW-1:0] quo_y;

	ppp_div #(.DW(PW), .VW(C - 1)) u_div_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.dividend  (pdx_s2),
		.divisor   (dsr_s2),
		.out_valid (div_vx),
		.quotient  (quo_x)
	);

	ppp_div #(.DW(PW), .VW(C - 1)) u_div_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.dividend  (pdy_s2),
		.divisor   (dsr_s2),
		.out_valid (div_vy),
		.quotient  (quo_y)
	);

	logic [SBW-1:0] side_s [PW+1];

	assign side_s[0] = {view_s2, dpos_s2, sx_s2, sy_s2, ma_s2, mu_s2};

	for (genvar k = 0; k < PW; k++) begin : g_side
		always_ff @(posedge clk) begin
			side_s[k+1] <= side_s[k];
		end
	end

	logic         sd_view;
	logic         sd_dpos;
	logic         sd_sx;
	logic         sd_sy;
	logic [C-1:0] sd_ma;
	logic [C-1:0] sd_mu;

	assign {sd_view, sd_dpos, sd_sx, sd_sy, sd_ma, sd_mu} = side_s[PW];

	// Output stage 1: select, clamp and sign the projected values.
	logic [PW-1:0] selx;
	logic [PW-1:0] sely;
	logic [MW-1:0] clx;
	logic [MW-1:0] cly;

	assign selx = sd_dpos ? quo_x : PW'(sd_ma);
	assign sely = sd_dpos ? quo_y : PW'(sd_mu);
	assign clx = (selx > LIM) ? LIM[MW-1:0] : selx[MW-1:0];
	assign cly = (sely > LIM) ? LIM[MW-1:0] : sely[MW-1:0];

	logic                 v_p1;
	logic                 view_p1;
	logic signed [QW-1:0] qx_p1;
	logic signed [QW-1:0] qy_p1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p1 <= 1'b0;
		end else begin
			v_p1 <= div_vx;
		end
	end

	always_ff @(posedge clk) begin
		view_p1 <= sd_view;
		qx_p1 <= sd_sx ? -$signed(QW'(clx)) : $signed(QW'(clx));
		qy_p1 <= sd_sy ? -$signed(QW'(cly)) : $signed(QW'(cly));
	end

	// Output stage 2: scale by screen size.
	logic                  v_p2;
	logic                  view_p2;
	logic signed [PXW-1:0] px_p2;
	logic signed [PXW-1:0] py_p2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p2 <= 1'b0;
		end else begin
			v_p2 <= v_p1;
		end
	end

	always_ff @(posedge clk) begin
		view_p2 <= view_p1;
		px_p2 <= qx_p1 * $signed({1'b0, width_q});
		py_p2 <= qy_p1 * $signed({1'b0, height_q});
	end

	// Output stage 3: offset to screen center, vertical axis flipped.
	logic signed [XW-1:0] offx;
	logic signed [XW-1:0] offy;

	assign offx = XW'(width_q[SCREEN_BITS-1:1]) << FRAC_BITS;
	assign offy = XW'(height_q - (height_q >> 1)) << FRAC_BITS;

	logic                 v_p3;
	logic                 view_p3;
	logic signed [XW-1:0] xv_p3;
	logic signed [XW-1:0] yv_p3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p3 <= 1'b0;
		end else begin
			v_p3 <= v_p2;
		end
	end

	always_ff @(posedge clk) begin
		view_p3 <= view_p2;
		xv_p3 <= XW'(px_p2) + offx;
		yv_p3 <= offy - XW'(py_p2);
	end

	// Output stage 4: truncate toward zero and saturate.
	localparam logic [XW-1:0] RND = XW'((64'd1 << FRAC_BITS) - 64'd1);

	logic signed [XW-1:0] adjx;
	logic signed [XW-1:0] adjy;
	logic signed [XW-1:0] pixx;
	logic signed [XW-1:0] pixy;
	logic signed [15:0]   satx;
	logic signed [15:0]   saty;

	assign adjx = xv_p3 + (xv_p3[XW-1] ? RND : '0);
	assign adjy = yv_p3 + (yv_p3[XW-1] ? RND : '0);
	assign pixx = adjx >>> FRAC_BITS;
	assign pixy = adjy >>> FRAC_BITS;

	always_comb begin
		if (!pixx[XW-1] && (pixx[XW-2:15] != '0)) begin
			satx = 16'sh7fff;
		end else if (pixx[XW-1] && (~pixx[XW-2:15] != '0)) begin
			satx = -16'sh8000;
		end else begin
			satx = pixx[15:0];
		end
		if (!pixy[XW-1] && (pixy[XW-2:15] != '0)) begin
			saty = 16'sh7fff;
		end else if (pixy[XW-1] && (~pixy[XW-2:15] != '0)) begin
			saty = -16'sh8000;
		end else begin
			saty = pixy[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= v_p3;
		end
	end

	always_ff @(posedge clk) begin
		screen_x <= satx;
		screen_y <= saty;
		in_view <= view_p3;
	end

`ifndef SYNTHESIS
	a_div_align: assert property (@(posedge clk) disable iff (!arst_n)
		div_vx == div_vy)
		else $error("dividers out of step");

	a_done_origin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without a started point");

	a_view_depth: assert property (@(posedge clk) disable iff (!arst_n)
		v_p1 && view_p1 |-> $past(sd_dpos))
		else $error("in view without positive depth");
`endif

endmodule

/* bench/tb_perspective_point_projection.sv */
module tb_perspective_point_projection;
	timeunit 1ns;
	timeprecision 1ps;
	import ppp_pkg::*;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic               v;
	} pixel_t;

	typedef struct {
		logic signed [31:0] d;
		logic signed [31:0] a;
		logic signed [31:0] u;
		bit                 typed;
		pixel_t             want;
	} point_row_t;

	typedef struct {
		logic [31:0] scale;
		logic [31:0] tan;
		logic [31:0] w;
		logic [31:0] h;
	} view_cfg_t;

	localparam int LATENCY = 70;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic signed [31:0] S_MAX = 32'sh7FFFFFFF;
	localparam logic signed [31:0] S_MIN = 32'sh80000000;
	localparam logic signed [31:0] ONE = 32'sh00010000;

	logic clk, arst_n, start, busy, done, in_view, cfg_valid, cfg_ready;
	logic signed [31:0] depth, across, up;
	logic signed [15:0] screen_x, screen_y;
	cfg_idx_t cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	logic [31:0] cur_scale, cur_tan;
	logic [SCREEN_BITS-1:0] cur_w, cur_h;
	pixel_t pending_pixels[$];
	int mismatches;
	int cycles;
	bit quiet;

	perspective_point_projection u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.depth(depth), .across(across), .up(up),
		.done(done), .screen_x(screen_x), .screen_y(screen_y), .in_view(in_view),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic longint axis_quotient(input longint c, input longint d);
		bit [63:0] m;
		if (d <= 0)
			return c;
		m = (c < 0) ? -c : c;
		m = m * 64'(cur_scale) / 64'(d);
		if (m > (64'd1 << 48))
			m = 64'd1 << 48;
		return (c < 0) ? -longint'(m) : longint'(m);
	endfunction

	function automatic logic [15:0] to_pixel(input longint v);
		longint p;
		if (v >= 0)
			p = v >>> 16;
		else
			p = -((-v) >>> 16);
		if (p > 32767)
			p = 32767;
		if (p < -32768)
			p = -32768;
		return p[15:0];
	endfunction

	function automatic pixel_t project_point(input logic signed [31:0] d, a, u);
		longint dl, al, ul, w, h, xv, yv;
		bit [63:0] lhs, rhs;
		pixel_t r;
		dl = d;
		al = a;
		ul = u;
		w = cur_w;
		h = cur_h;
		xv = w * axis_quotient(al, dl) + (w / 2) * 65536;
		yv = (h - h / 2) * 65536 - h * axis_quotient(ul, dl);
		r.x = to_pixel(xv);
		r.y = to_pixel(yv);
		lhs = 64'(al) << 16;
		rhs = 64'(cur_tan) * 64'(dl);
		r.v = (dl > 0) && ((al < 0) || (lhs < rhs));
		return r;
	endfunction

	task automatic idle_gap();
		int r, n;
		r = $urandom_range(0, 99);
		if (quiet || r < 50)
			n = 0;
		else if (r < 90)
			n = $urandom_range(1, 3);
		else
			n = $urandom_range(10, 40);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_point(input point_row_t row);
		idle_gap();
		start <= 1'b1;
		depth <= row.d;
		across <= row.a;
		up <= row.u;
		do @(posedge clk); while (busy);
		pending_pixels.push_back(row.typed ? row.want : project_point(row.d, row.a, row.u));
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_SCALE: cur_scale = val;
			CFG_TAN: cur_tan = val;
			CFG_WIDTH: cur_w = val[SCREEN_BITS-1:0];
			CFG_HEIGHT: cur_h = val[SCREEN_BITS-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_cfg(input view_cfg_t c);
		write_reg(CFG_SCALE, c.scale);
		write_reg(CFG_TAN, c.tan);
		write_reg(CFG_WIDTH, c.w);
		write_reg(CFG_HEIGHT, c.h);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic signed [31:0] rand_coord(input bit for_depth);
		int r;
		r = $urandom_range(0, 9);
		if (for_depth && r < 5)
			return $urandom_range(1, 200 * 65536);
		if (r < 7)
			return $signed($urandom_range(0, 400 * 65536)) - 200 * 65536;
		if (r == 7)
			return for_depth ? 32'sd0 : $signed($urandom_range(0, 2 * 65536)) - 65536;
		return $urandom();
	endfunction

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result x=%0d y=%0d v=%0b", screen_x, screen_y, in_view);
			end else begin
				pixel_t e;
				e = pending_pixels.pop_front();
				if (e.x !== screen_x || e.y !== screen_y || e.v !== in_view) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch: expected x=%0d y=%0d v=%0b, got x=%0d y=%0d v=%0b",
							e.x, e.y, e.v, screen_x, screen_y, in_view);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		point_row_t rows[$];
		point_row_t row;
		view_cfg_t cfgs[$];
		view_cfg_t c;
		int waited;
		mismatches = 0;
		cycles = 0;
		quiet = 0;
		start = 1'b0;
		depth = '0;
		across = '0;
		up = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_SCALE;
		cfg_data = '0;
		cur_scale = SCALE_RESET;
		cur_tan = TAN_RESET;
		cur_w = WIDTH_RESET;
		cur_h = HEIGHT_RESET;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		rows = '{
			'{32'sd0, 32'sd0, 32'sd0, 1'b1, '{16'sd320, 16'sd240, 1'b0}},
			'{ONE, 32'sd0, 32'sd0, 1'b1, '{16'sd320, 16'sd240, 1'b1}},
			'{-ONE, S_MAX, S_MIN, 1'b1, '{16'sd32767, 16'sd32767, 1'b0}},
			'{-ONE, S_MIN, S_MAX, 1'b1, '{-16'sd32768, -16'sd32768, 1'b0}},
			'{32'sd1, S_MAX, S_MIN, 1'b0, '0},
			'{32'sd1, S_MIN, S_MAX, 1'b0, '0},
			'{S_MAX, S_MIN, S_MAX, 1'b0, '0},
			'{S_MAX, 32'sd0, 32'sd1, 1'b0, '0},
			'{S_MIN, 32'sd1, -32'sd1, 1'b0, '0},
			'{ONE, ONE - 1, ONE, 1'b0, '0},
			'{ONE, ONE, -ONE, 1'b0, '0},
			'{ONE, -32'sd1, 32'sd5, 1'b0, '0},
			'{32'sd1, 32'sd1, 32'sd1, 1'b0, '0},
			'{-32'sd1, 32'sd12345, -32'sd98765, 1'b0, '0},
			'{4 * ONE, ONE, ONE, 1'b0, '0},
			'{32'shFFFF_FFFF, 32'sh5555_5555, 32'shAAAA_AAAA, 1'b0, '0}
		};
		foreach (rows[i])
			send_point(rows[i]);
		drain();

		cfgs = '{
			'{32'd32768, 32'd65536, 32'd640, 32'd480},
			'{32'd0, 32'd0, 32'd1, 32'd1},
			'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd8192, 32'd8192},
			'{32'd65536, 32'd1, 32'd0, 32'd16383},
			'{32'd131072, 32'd45000, 32'd1920, 32'd1080},
			'{$urandom(), $urandom(), $urandom_range(1, 8192), $urandom_range(1, 8192)}
		};
		foreach (cfgs[k]) begin
			apply_cfg(cfgs[k]);
			quiet = (k % 2 == 1);
			repeat (245) begin
				row.d = rand_coord(1'b1);
				row.a = rand_coord(1'b0);
				row.u = rand_coord(1'b0);
				row.typed = 1'b0;
				row.want = '0;
				send_point(row);
			end
			drain();
		end

		waited = 0;
		while (waited < LATENCY + 10) begin
			@(posedge clk);
			waited++;
		end
		if (mismatches == 0 && pending_pixels.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
